FILE: rtl/ibfr_pkg.sv
// Package for the iBUS frame receiver: constants, state and cell control types.
package ibfr_pkg;

	localparam int FRAME_BYTES_DEF = 32;
	localparam int MAX_CH          = 14;
	localparam int CH_W            = 4;

	localparam logic [7:0]  HDR0      = 8'h20;
	localparam logic [7:0]  HDR1      = 8'h40;
	localparam logic [15:0] CSUM_INIT = 16'hFFFF;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT1,
		CELL_SHIFT2
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [7:0] load_byte;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CHECK,
		ST_DROP,
		ST_SKIP,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/ibfr_if.sv
// Handshake channel interfaces for received bytes and decoded channels.
interface ibfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ibfr_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic        last_channel;

	modport source (output valid, output channel_index, output channel_value,
		output last_channel, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input last_channel, output ready);
endinterface

FILE: rtl/ibfr_cell.sv
// One byte cell of the receive window: hold, load, or take a neighbor's byte.
module ibfr_cell
	import ibfr_pkg::*;
(
	input  logic       clk,
	input  cell_ctl_t  ctl,
	input  logic [7:0] next1,
	input  logic [7:0] next2,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD:   byte_q <= ctl.load_byte;
			CELL_SHIFT1: byte_q <= next1;
			CELL_SHIFT2: byte_q <= next2;
			default:     byte_q <= byte_q;
		endcase
	end

	assign q = byte_q;

endmodule

FILE: rtl/ibus_frame_receiver.sv
// Top level of the iBUS frame receiver: byte window, frame sequencer and output register.
//
// Receives one serial byte per transfer on rx and delivers the channels of each
// valid iBUS frame on ch_out, one channel per transfer, the last one flagged.
// The window is a row of FRAME_BYTES byte cells; every cell takes the byte of
// its right-hand neighbor (or the one two places over) when the window moves,
// and the last cells wrap around to the first, so a full pass of shifts
// rotates the window back into place. A byte that leaves the window short of
// full is loaded into its cell and the next byte can be taken in the following cycle.
// The byte that fills the window starts a sequence that owns the row of cells:
// it looks for the 0x20 0x40 header at the front and drops leading bytes one
// by one until it leads; when the header already leads, it rotates the window
// once past the checksum adder, then drops a byte on a mismatch, or on a
// match steps over the header and hands out the channels (14 at the default
// size) one by one as ch_out takes them. The longest sequence is a good frame,
// and every hold-off of a channel by ch_out stretches it further; in that
// time rx is held not ready. The last channel sits in the output register
// while the next byte is already being taken.
module ibus_frame_receiver
	import ibfr_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ibfr_in_if.sink           rx,
	ibfr_out_if.source        ch_out
);

	localparam int FW      = $clog2(FRAME_BYTES + 1);
	localparam int KW      = $clog2(FRAME_BYTES);
	localparam int CH_RAW  = (FRAME_BYTES - 4) / 2;
	localparam int NUM_CH  = (CH_RAW > MAX_CH) ? MAX_CH : CH_RAW;

	state_t state_q, state_d;

	logic [FW-1:0]   fill_q;
	logic [KW-1:0]   k_q;
	logic [15:0]     sum_q;
	logic [7:0]      lo_q;
	logic [CH_W-1:0] ch_q;
	logic            dropped_q;

	logic            out_valid_q;
	logic [CH_W-1:0] out_idx_q;
	logic [15:0]     out_val_q;
	logic            out_last_q;

	logic [7:0] cell_q [FRAME_BYTES];
	cell_ctl_t  ctl_c  [FRAME_BYTES];

	logic       accept;
	logic       pair_at_front;
	logic       csum_match;
	logic       out_free;
	logic       last_ch;
	logic       fill_one;
	logic       check_done;
	logic       emit_now;
	cell_op_t   row_op;

	assign accept        = rx.valid && rx.ready;
	assign pair_at_front = (cell_q[0] == HDR0) && (cell_q[1] == HDR1);
	assign csum_match    = (sum_q == {cell_q[0], lo_q});
	assign out_free      = !out_valid_q || ch_out.ready;
	assign last_ch       = (ch_q == CH_W'(NUM_CH - 1));
	assign fill_one      = (fill_q == FW'(1));
	assign check_done    = (k_q == KW'(FRAME_BYTES - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && fill_q == FW'(FRAME_BYTES - 1)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (pair_at_front) begin
					state_d = dropped_q ? ST_IDLE : ST_CHECK;
				end else if (fill_one) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if (check_done) begin
					state_d = csum_match ? ST_SKIP : ST_DROP;
				end
			end
			ST_DROP: state_d = ST_IDLE;
			ST_SKIP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free && last_ch) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: how the row of cells moves, when a channel leaves
	always_comb begin
		row_op   = CELL_HOLD;
		emit_now = 1'b0;
		unique case (state_q)
			ST_IDLE:   row_op = CELL_HOLD;
			ST_SEARCH: begin
				if (!pair_at_front && !fill_one) begin
					row_op = CELL_SHIFT1;
				end
			end
			ST_CHECK:  row_op = CELL_SHIFT1;
			ST_DROP:   row_op = CELL_SHIFT1;
			ST_SKIP:   row_op = CELL_SHIFT2;
			ST_EMIT: begin
				if (out_free) begin
					row_op   = CELL_SHIFT2;
					emit_now = 1'b1;
				end
			end
			default:   row_op = CELL_HOLD;
		endcase
	end

	assign rx.ready = (state_q == ST_IDLE);

	// Row of byte cells; the tail wraps to the head so a full pass rotates
	for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
		always_comb begin
			ctl_c[i].load_byte = rx.rx_byte;
			if (state_q == ST_IDLE) begin
				ctl_c[i].op = (accept && fill_q == FW'(i)) ? CELL_LOAD : CELL_HOLD;
			end else begin
				ctl_c[i].op = row_op;
			end
		end

		ibfr_cell u_cell (
			.clk   (clk),
			.ctl   (ctl_c[i]),
			.next1 (cell_q[(i + 1) % FRAME_BYTES]),
			.next2 (cell_q[(i + 2) % FRAME_BYTES]),
			.q     (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			k_q       <= '0;
			ch_q      <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q    <= fill_q + FW'(1);
						dropped_q <= 1'b0;
						k_q       <= '0;
					end
				end
				ST_SEARCH: begin
					// drop one leading byte per cycle until the header leads
					if (!pair_at_front && !fill_one) begin
						fill_q    <= fill_q - FW'(1);
						dropped_q <= 1'b1;
					end
				end
				ST_CHECK: k_q <= k_q + KW'(1);
				ST_DROP:  fill_q <= fill_q - FW'(1);
				ST_SKIP:  ch_q <= '0;
				ST_EMIT: begin
					if (out_free) begin
						ch_q <= ch_q + CH_W'(1);
						if (last_ch) begin
							fill_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Checksum accumulator: subtract every byte but the last two as they pass the front
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			sum_q <= CSUM_INIT;
		end else if (state_q == ST_CHECK) begin
			if (k_q < KW'(FRAME_BYTES - 2)) begin
				sum_q <= sum_q - {8'h00, cell_q[0]};
			end
			if (k_q == KW'(FRAME_BYTES - 2)) begin
				lo_q <= cell_q[0];
			end
		end
	end

	// Output register: hold a channel until ch_out takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (ch_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_idx_q  <= ch_q;
			out_val_q  <= {cell_q[1], cell_q[0]};
			out_last_q <= last_ch;
		end
	end

	assign ch_out.valid         = out_valid_q;
	assign ch_out.channel_index = out_idx_q;
	assign ch_out.channel_value = out_val_q;
	assign ch_out.last_channel  = out_last_q;

`ifndef SYNTH
	a_fill_below_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> fill_q < FW'(FRAME_BYTES))
		else $error("window full while idle");

	a_check_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> fill_q == FW'(FRAME_BYTES) && !dropped_q)
		else $error("checksum pass on a window that is not a full aligned frame");

	a_skip_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SKIP |=> state_q == ST_EMIT && ch_q == '0)
		else $error("channel emission did not start at channel zero");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_idx_q == CH_W'(NUM_CH - 1))
		else $error("last flag on a channel other than the final one");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now && last_ch |=> fill_q == '0 && state_q == ST_IDLE)
		else $error("window not cleared after a frame");
`endif

endmodule

FILE: tb/sv/ibfr_channel_checker.sv
// Channel checker for the iBUS frame receiver: tracks the byte window and checks every channel.
`timescale 1ns / 1ps

module ibfr_channel_checker
	import ibfr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	ibfr_in_if    rx,
	ibfr_out_if   ch_out,
	output int    errors,
	output int    pending,
	output int    bytes_seen,
	output int    frames_seen,
	output int    channels_seen
);

	localparam int FB           = FRAME_BYTES_DEF;
	localparam int CH_FROM_SIZE = (FB - 4) / 2;
	localparam int NUM_CH       = (CH_FROM_SIZE > MAX_CH) ? MAX_CH : CH_FROM_SIZE;

	typedef struct packed {
		logic [CH_W-1:0] idx;
		logic [15:0]     value;
		logic            last;
	} channel_t;

	logic [7:0] window [FB];
	int         fill;
	channel_t   expected_channels [$];
	int         err_n   = 0;
	int         byte_n  = 0;
	int         frame_n = 0;
	int         chan_n  = 0;

	function automatic void drop_lead(int n);
		int i;
		if (n >= fill) begin
			fill = 0;
			return;
		end
		for (i = 0; i < fill - n; i++)
			window[i] = window[i + n];
		fill = fill - n;
	endfunction

	// Append one byte; align, verify the checksum and queue channels on a good frame.
	function automatic void take_rx_byte(logic [7:0] b);
		int          head;
		int          i;
		logic [15:0] csum;
		logic [15:0] sent_sum;
		channel_t    c;
		if (fill >= FB)
			fill = FB - 1;
		window[fill] = b;
		fill++;
		if (fill < FB)
			return;
		head = 0;
		while (head + 1 < fill && !(window[head] == HDR0 && window[head + 1] == HDR1))
			head++;
		if (head > 0) begin
			drop_lead(head);
			return;
		end
		csum = CSUM_INIT;
		for (i = 0; i < FB - 2; i++)
			csum = csum - {8'h00, window[i]};
		sent_sum = {window[FB-1], window[FB-2]};
		if (csum != sent_sum) begin
			drop_lead(1);
			return;
		end
		for (i = 0; i < NUM_CH; i++) begin
			c.idx   = i[CH_W-1:0];
			c.value = {window[3 + 2*i], window[2 + 2*i]};
			c.last  = (i == NUM_CH - 1);
			expected_channels.push_back(c);
		end
		fill = 0;
		frame_n++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		channel_t want;
		if (!arst_n) begin
			fill = 0;
			expected_channels.delete();
		end else begin
			if (rx.valid && rx.ready) begin
				byte_n++;
				take_rx_byte(rx.rx_byte);
			end
			if (ch_out.valid && ch_out.ready) begin
				chan_n++;
				if (expected_channels.size() == 0) begin
					$error("channel transfer with nothing expected: index %0d value %h",
						ch_out.channel_index, ch_out.channel_value);
					err_n++;
				end else begin
					want = expected_channels.pop_front();
					if (ch_out.channel_index !== want.idx) begin
						$error("channel_index: expected %0d, got %0d",
							want.idx, ch_out.channel_index);
						err_n++;
					end
					if (ch_out.channel_value !== want.value) begin
						$error("channel_value: expected %h, got %h",
							want.value, ch_out.channel_value);
						err_n++;
					end
					if (ch_out.last_channel !== want.last) begin
						$error("last_channel: expected %0d, got %0d",
							want.last, ch_out.last_channel);
						err_n++;
					end
				end
			end
		end
		errors        <= err_n;
		pending       <= expected_channels.size();
		bytes_seen    <= byte_n;
		frames_seen   <= frame_n;
		channels_seen <= chan_n;
	end

endmodule

FILE: tb/sv/ibus_frame_receiver_tb.sv
// Testbench top for the iBUS frame receiver: byte stimulus, sink back-pressure and verdict.
`timescale 1ns / 1ps

module ibus_frame_receiver_tb;
	import ibfr_pkg::*;

	localparam int FB = FRAME_BYTES_DEF;

	// How the channel bytes of a generated frame are filled.
	typedef enum int {
		FILL_RANDOM,
		FILL_ONES,
		FILL_ZEROS,
		FILL_HEADERS,
		FILL_MIXED
	} fill_mode_t;

	typedef logic [7:0] frame_bytes_t [FB];

	logic clk;
	logic arst_n;

	ibfr_in_if  rx_bus ();
	ibfr_out_if ch_bus ();

	int errors;
	int pending;
	int bytes_seen;
	int frames_seen;
	int channels_seen;

	// Stimulus-side controls read by the sink process, and the count of bytes sent.
	logic no_idle;
	logic sink_hold_req;
	int   rand_sent;

	ibus_frame_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_bus),
		.ch_out (ch_bus)
	);

	ibfr_channel_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx            (rx_bus),
		.ch_out        (ch_bus),
		.errors        (errors),
		.pending       (pending),
		.bytes_seen    (bytes_seen),
		.frames_seen   (frames_seen),
		.channels_seen (channels_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block deadlocks.
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// Offer one byte and hold it until the block takes the transfer.
	// Now and then drop valid for a random burst first.
	task automatic send_byte(input logic [7:0] b);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			rx_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		rx_bus.valid   <= 1'b1;
		rx_bus.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_bus.ready);
		rand_sent++;
	endtask

	// Build a frame with the header, channel bytes per mode and the checksum,
	// optionally spoil the checksum, then send bytes from first_byte onward.
	task automatic send_frame(input fill_mode_t mode, input bit corrupt, input int first_byte);
		frame_bytes_t f;
		logic [15:0]  csum;
		int           i;
		f[0] = HDR0;
		f[1] = HDR1;
		for (i = 2; i < FB - 2; i++) begin
			case (mode)
				FILL_ONES:    f[i] = 8'hFF;
				FILL_ZEROS:   f[i] = 8'h00;
				FILL_HEADERS: f[i] = $urandom_range(0, 1) ? HDR0 : HDR1;
				FILL_MIXED: begin
					case ($urandom_range(0, 5))
						0:       f[i] = HDR0;
						1:       f[i] = HDR1;
						2:       f[i] = 8'hFF;
						3:       f[i] = 8'h00;
						default: f[i] = 8'($urandom_range(0, 255));
					endcase
				end
				default:      f[i] = 8'($urandom_range(0, 255));
			endcase
		end
		csum = CSUM_INIT;
		for (i = 0; i < FB - 2; i++)
			csum = csum - {8'h00, f[i]};
		if (corrupt)
			csum = csum ^ 16'($urandom_range(1, 16'hFFFF));
		f[FB-2] = csum[7:0];
		f[FB-1] = csum[15:8];
		for (i = first_byte; i < FB; i++)
			send_byte(f[i]);
	endtask

	function automatic fill_mode_t pick_mode();
		case ($urandom_range(0, 9))
			0:       return FILL_HEADERS;
			1, 2, 3: return FILL_MIXED;
			default: return FILL_RANDOM;
		endcase
	endfunction

	// Sink side: random ready bursts, plus one long hold-off on request so
	// the output register fills and the block stops taking bytes.
	initial begin
		int gap;
		bit held;
		gap  = 0;
		held = 0;
		ch_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req && !held) begin
				held = 1;
				ch_bus.ready <= 1'b0;
				repeat (600) @(posedge clk);
			end else if (gap > 0) begin
				ch_bus.ready <= 1'b0;
				gap--;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14) - 1;
				ch_bus.ready <= 1'b0;
			end else begin
				ch_bus.ready <= 1'b1;
			end
		end
	end

	// Main stimulus.
	initial begin
		int  i;
		int  n;
		int  w;
		int  pick;
		bit  hold_done;
		bit  pause_done;

		arst_n         <= 1'b0;
		rx_bus.valid   <= 1'b0;
		rx_bus.rx_byte <= 8'h00;
		no_idle        <= 1'b0;
		sink_hold_req  <= 1'b0;
		rand_sent      = 0;
		hold_done      = 0;
		pause_done     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme channel values.
		send_frame(FILL_ONES, 0, 0);
		send_frame(FILL_ZEROS, 0, 0);

		// Header not at the front: junk bytes ahead of a good frame.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR1);
		send_frame(FILL_RANDOM, 0, 0);

		// Checksum mismatch, then a good frame that must still be found.
		send_frame(FILL_RANDOM, 1, 0);
		send_frame(FILL_RANDOM, 0, 0);

		// No header pair anywhere: a full window of lone 0x20 bytes keeps only
		// the last one, which then serves as the header of the next frame.
		for (i = 0; i < FB; i++)
			send_byte(HDR0);
		send_frame(FILL_MIXED, 0, 1);

		// Random part: mostly well-formed frames with random content, plus
		// junk prefixes, bad checksums, cut-off frames and loose noise.
		while (rand_sent < 450) begin
			if (!hold_done && rand_sent >= 250) begin
				// Long sink stall while frames keep coming.
				hold_done = 1;
				sink_hold_req <= 1'b1;
				send_frame(FILL_RANDOM, 0, 0);
				send_frame(FILL_MIXED, 0, 0);
			end else if (!pause_done && rand_sent >= 340) begin
				// Sender goes quiet until every channel has drained.
				pause_done = 1;
				rx_bus.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end else begin
				if (rand_sent >= 390)
					no_idle <= 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					send_frame(pick_mode(), 0, 0);
				end else if (pick < 70) begin
					n = $urandom_range(1, 5);
					for (i = 0; i < n; i++)
						send_byte(8'($urandom_range(0, 255)));
					send_frame(pick_mode(), 0, 0);
				end else if (pick < 80) begin
					send_frame(pick_mode(), 1, 0);
				end else if (pick < 88) begin
					send_byte(HDR0);
					send_byte(HDR1);
					n = $urandom_range(1, 20);
					for (i = 0; i < n; i++)
						send_byte(8'($urandom_range(0, 255)));
				end else begin
					n = $urandom_range(1, 6);
					for (i = 0; i < n; i++)
						send_byte(8'($urandom_range(0, 255)));
				end
			end
		end
		rx_bus.valid <= 1'b0;

		// Drain: wait for the outstanding channels, then let the block settle.
		@(posedge clk);
		for (w = 0; w < 20000 && pending != 0; w++)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Run covered %0d bytes and %0d good frames; %0d channel transfers checked.",
			bytes_seen, frames_seen, channels_seen);
		$display("Included junk prefixes, bad checksums, cut-off frames and a long sink stall.");
		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			if (pending != 0)
				$error("%0d expected channel transfers never arrived", pending);
			$display("FAIL");
		end
		$finish;
	end

endmodule
